// ===== hw/rtl/twr_pkg.sv =====
// Shared types and constants of the text terminal writer.
`default_nettype none
package twr_pkg;

   // Fixed widths of the cursor and cell fields
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int LIN_W  = 11;
   localparam int CELL_W = 16;

   // Item function codes
   localparam logic [1:0] FUNC_PUT   = 2'd0;
   localparam logic [1:0] FUNC_PLACE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Character codes and reset attribute
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_RETURN  = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h07;

   // Configuration register index (word address bit)
   localparam logic REG_TEXT_ATTR = 1'b0;

   // Screen memory operation carried by a command
   typedef enum logic [1:0] {
      OP_NOP   = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // One classified command from the front to the back
   typedef struct packed {
      op_type              op;
      logic [CELL_W-1:0]   cell_word;
      logic                scroll;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic [LIN_W-1:0]    linear;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/twr_front.sv =====
// Front part: tracks the cursor and scroll offset, turns each item into a command.
`default_nettype none
module twr_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int AW      = 11
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [1:0]                func,
   input  wire logic [7:0]                char_code,
   input  wire logic [7:0]                cell_attribute,
   input  wire logic [twr_pkg::ROW_W-1:0] cell_row,
   input  wire logic [twr_pkg::COL_W-1:0] cell_col,
   input  wire logic [7:0]                text_attr,
   output twr_pkg::cmd_type               cmd,
   output logic [AW-1:0]                  addr
);
   import twr_pkg::*;

   localparam logic [ROW_W:0]   ROWS_C   = (ROW_W+1)'(ROWS);
   localparam logic [COL_W:0]   COLS_C   = (COL_W+1)'(COLUMNS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] top_ff, top_in;
   logic             adv_row;
   logic             scroll;
   logic             in_range;
   op_type           op;
   logic [CELL_W-1:0] cell_word;
   logic [ROW_W-1:0] wr_row;
   logic [COL_W-1:0] wr_col;
   logic [ROW_W:0]   row_sum;
   logic [ROW_W-1:0] phys_row;
   logic [11:0]      addr_full;
   logic [11:0]      lin_full;

   assign in_range = ({1'b0, cell_row} < ROWS_C) && ({1'b0, cell_col} < COLS_C);

   // Classify the item and work out the new cursor
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      top_in    = top_ff;
      adv_row   = 1'b0;
      scroll    = 1'b0;
      op        = OP_NOP;
      cell_word = '0;
      wr_row    = row_ff;
      wr_col    = col_ff;
      case (func)
         FUNC_PUT: begin
            if (char_code == CH_NEWLINE) begin
               col_in  = '0;
               adv_row = 1'b1;
            end else if (char_code == CH_RETURN) begin
               col_in = '0;
            end else begin
               op        = OP_WRITE;
               cell_word = {text_attr, char_code};
               if (col_ff == LAST_COL) begin
                  col_in  = '0;
                  adv_row = 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            if (adv_row) begin
               if (row_ff == LAST_ROW) begin
                  scroll = 1'b1;
                  top_in = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         FUNC_PLACE: begin
            wr_row = cell_row;
            wr_col = cell_col;
            if (in_range) begin
               op        = OP_WRITE;
               cell_word = {cell_attribute, char_code};
            end
         end
         FUNC_READ: begin
            wr_row = cell_row;
            wr_col = cell_col;
            if (in_range) begin
               op = OP_READ;
            end
         end
         default: begin
            op = OP_NOP;
         end
      endcase
   end

   // Map the logical row onto the rotating screen memory
   assign row_sum   = {1'b0, wr_row} + {1'b0, top_ff};
   assign phys_row  = (row_sum >= ROWS_C) ? ROW_W'(row_sum - ROWS_C) : row_sum[ROW_W-1:0];
   assign addr_full = 12'(phys_row) * 12'(COLUMNS) + 12'(wr_col);
   assign addr      = addr_full[AW-1:0];

   // Linear cursor position after the item
   assign lin_full = 12'(row_in) * 12'(COLUMNS) + 12'(col_in);

   always_comb begin
      cmd.op        = op;
      cmd.cell_word = cell_word;
      cmd.scroll    = scroll;
      cmd.row       = row_in;
      cmd.col       = col_in;
      cmd.linear    = lin_full[LIN_W-1:0];
   end

   // Advance the cursor on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         top_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
         top_ff <= top_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/twr_cmd_fifo.sv =====
// Short command queue between the front and the back.
`default_nettype none
module twr_cmd_fifo #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  full,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] store [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store[rd_ptr_ff];

   // Advance the pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/twr_back.sv =====
// Back part: owns the screen memory, executes commands, clears rows and holds results.
`default_nettype none
module twr_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int AW      = 11
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire twr_pkg::cmd_type          cmd,
   input  wire logic [AW-1:0]             cmd_addr,
   input  wire logic                      cmd_empty,
   output logic                           cmd_pop,
   input  wire logic [7:0]                text_attr,
   output logic                           init_busy,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic [7:0]                     rsp_read_char,
   output logic [7:0]                     rsp_read_attr,
   output logic [twr_pkg::ROW_W-1:0]      rsp_cursor_row_now,
   output logic [twr_pkg::COL_W-1:0]      rsp_cursor_col_now,
   output logic [twr_pkg::LIN_W-1:0]      rsp_cursor_linear,
   output logic                           rsp_scrolled
);
   import twr_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int CNT_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
   localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(COLUMNS - 1);

   typedef enum logic [4:0] {
      S_INIT  = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_CLEAR = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   logic [CELL_W-1:0] screen_mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   cmd_type           cur_ff, cur_in;
   logic [CELL_W-1:0] res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cmd_type           out_cmd_ff;
   logic [CELL_W-1:0] out_cell_ff;
   logic              out_load;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [CELL_W-1:0] mem_wd;
   logic [AW-1:0]     clr_next;

   assign clr_next  = (clr_addr_ff == LAST_CELL) ? '0 : clr_addr_ff + 1'b1;
   assign init_busy = (state_ff == S_INIT);

   // Sweep the memory after reset, then sequence the memory work of one command
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      res_in      = res_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = clr_addr_ff;
      mem_wd      = {RESET_ATTR, CH_SPACE};
      out_load    = 1'b0;
      case (state_ff)
         S_INIT: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_next;
            if (clr_addr_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               res_in  = '0;
               if (cmd.op == OP_WRITE) begin
                  mem_we = 1'b1;
                  mem_wa = cmd_addr;
                  mem_wd = cmd.cell_word;
               end
               if (cmd.op == OP_READ) begin
                  state_in = S_READ;
               end else if (cmd.scroll) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_READ: begin
            res_in   = rd_data_ff;
            state_in = S_EMIT;
         end
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_wd      = {text_attr, CH_SPACE};
            clr_addr_in = clr_next;
            if (cnt_ff == LAST_CNT) begin
               cnt_in   = '0;
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until it is popped
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_addr_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      res_ff <= res_in;
      if (out_load) begin
         out_cmd_ff  <= cur_ff;
         out_cell_ff <= res_in;
      end
   end

   // Screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= screen_mem[cmd_addr];
   end

   assign rsp_empty          = !rsp_valid_ff;
   assign rsp_read_char      = out_cell_ff[7:0];
   assign rsp_read_attr      = out_cell_ff[15:8];
   assign rsp_cursor_row_now = out_cmd_ff.row;
   assign rsp_cursor_col_now = out_cmd_ff.col;
   assign rsp_cursor_linear  = out_cmd_ff.linear;
   assign rsp_scrolled       = out_cmd_ff.scroll;

endmodule
`default_nettype wire

// ===== hw/rtl/text_mode_terminal_writer_core.sv =====
// Top level of the text terminal writer: configuration register, front, queue and back.
//
//   channel   ports                          beat taken when
//   --------  -----------------------------  ---------------------------------
//   request   req_push/req_full + fields     req_push && !req_full
//   response  rsp_empty/rsp_pop + fields     rsp_pop && !rsp_empty
//   config    csr_psel/penable/pwrite/...    psel && penable && pwrite
//
// After reset the screen memory is swept to spaces in attribute 0x07, one cell a
// cycle, through all ROWS*COLUMNS cells; req_full stays high meanwhile.
// The front takes a beat every cycle while its four-entry queue has room.
// The back takes a write or no-op through IDLE and EMIT, a read through IDLE, READ and
// EMIT; a scroll adds CLEAR, clearing the recycled row through the single write port.
// A result waiting in the output register holds the back; the front keeps taking
// beats until the queue fills, then req_full rises.
`default_nettype none
module text_mode_terminal_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request queue
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire logic [1:0]                req_func,
   input  wire logic [7:0]                req_char_code,
   input  wire logic [7:0]                req_cell_attribute,
   input  wire logic [twr_pkg::ROW_W-1:0] req_cell_row,
   input  wire logic [twr_pkg::COL_W-1:0] req_cell_col,
   // response (one-entry result register)
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic [7:0]                     rsp_read_char,
   output logic [7:0]                     rsp_read_attr,
   output logic [twr_pkg::ROW_W-1:0]      rsp_cursor_row_now,
   output logic [twr_pkg::COL_W-1:0]      rsp_cursor_col_now,
   output logic [twr_pkg::LIN_W-1:0]      rsp_cursor_linear,
   output logic                           rsp_scrolled,
   // configuration
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [2:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import twr_pkg::*;

   localparam int AW = $clog2(ROWS * COLUMNS);
   localparam int CW = $bits(cmd_type) + AW;

   logic [7:0]    attr_ff, attr_in;
   logic          cfg_write;
   logic          accept;
   logic          init_busy;
   cmd_type       front_cmd;
   logic [AW-1:0] front_addr;
   logic [CW-1:0] q_rdata;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   cmd_type       back_cmd;
   logic [AW-1:0] back_addr;

   // Text attribute register
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_TEXT_ATTR);
   assign attr_in    = cfg_write ? csr_pwdata[7:0] : attr_ff;
   assign csr_prdata = (csr_paddr[2] == REG_TEXT_ATTR) ? {24'd0, attr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // Take a beat when the queue has room and the sweep is done
   assign req_full = q_full || init_busy;
   assign accept   = req_push && !req_full;

   twr_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .func           (req_func),
      .char_code      (req_char_code),
      .cell_attribute (req_cell_attribute),
      .cell_row       (req_cell_row),
      .cell_col       (req_cell_col),
      .text_attr      (attr_ff),
      .cmd            (front_cmd),
      .addr           (front_addr)
   );

   twr_cmd_fifo #(
      .WIDTH (CW),
      .DEPTH (4)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata ({front_cmd, front_addr}),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   assign back_cmd  = cmd_type'(q_rdata[CW-1:AW]);
   assign back_addr = q_rdata[AW-1:0];

   twr_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd                (back_cmd),
      .cmd_addr           (back_addr),
      .cmd_empty          (q_empty),
      .cmd_pop            (q_pop),
      .text_attr          (attr_ff),
      .init_busy          (init_busy),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_attr      (rsp_read_attr),
      .rsp_cursor_row_now (rsp_cursor_row_now),
      .rsp_cursor_col_now (rsp_cursor_col_now),
      .rsp_cursor_linear  (rsp_cursor_linear),
      .rsp_scrolled       (rsp_scrolled)
   );

endmodule
`default_nettype wire
